### design/smx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_pkg: shared types and constants for the softmax vector unit.
// Holds the exponent table, the controller states and the command struct.
// ----------------------------------------------------------------------------
package smx_pkg;

    localparam int DEF_MAX_CLASSES     = 64;
    localparam int DEF_EXP_TABLE_DEPTH = 256;
    localparam int EXP_W               = 28;
    localparam int SUM_W               = 34;
    localparam int PROB_W              = 16;
    localparam int LOG2E_Q16           = 94548;
    localparam int QUOT_W              = 17;

    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_EXP,
        ST_READ,
        ST_DIVIDE,
        ST_EMIT
    } smx_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic store;
        logic read;
        logic div_start;
        logic emit;
        logic clear;
    } smx_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
        logic last_seen;
        logic last_elem;
    } smx_status_t;

    // Table word k: 2^(k/depth) in Q16, truncated Taylor series in Q30.
    function automatic logic [31:0] exp_rom_word(input int k, input int depth);
        logic [63:0] t;
        logic [63:0] term;
        logic [63:0] acc;
        t    = (64'(k) * 64'd744261118) / 64'(depth);
        term = 64'd1 << 30;
        acc  = term;
        for (int i = 1; i <= 14; i++)
        begin
            term = ((term * t) >> 30) / 64'(i);
            acc  = acc + term;
        end
        return 32'((acc + (64'd1 << 13)) >> 14);
    endfunction

endpackage

### design/smx_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_datapath: exponent unit, store, running sum and restoring divider.
// Works on the commands of the controller and reports divider done, last_seen and last_elem.
// ----------------------------------------------------------------------------
module smx_datapath
    import smx_pkg::*;
#(
    parameter int MAX_CLASSES     = DEF_MAX_CLASSES,
    parameter int EXP_TABLE_DEPTH = DEF_EXP_TABLE_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic signed [15:0]  logit,
    input  logic                last_in,
    input  smx_cmd_t            cmd,
    output smx_status_t         status,
    output logic [PROB_W-1:0]   probability,
    output logic                last_out,
    output logic                overflowed
);

    localparam int IDX_W  = $clog2(EXP_TABLE_DEPTH);
    localparam int ADDR_W = $clog2(MAX_CLASSES);
    localparam int CNT_W  = $clog2(MAX_CLASSES + 1);
    localparam int DIVIDEND_W = EXP_W + 16;
    localparam int DIV_STEPS  = QUOT_W;
    localparam int STEP_W     = $clog2(DIV_STEPS + 1);

    function automatic logic [16:0] rom_lookup(input logic [IDX_W-1:0] k);
        logic [16:0] words [EXP_TABLE_DEPTH];
        for (int i = 0; i < EXP_TABLE_DEPTH; i++)
        begin
            words[i] = 17'(exp_rom_word(i, EXP_TABLE_DEPTH));
        end
        return words[k];
    endfunction

    logic [35:0]          prod_reg;
    logic                 last_reg;
    logic [EXP_W-1:0]     exp_mem [MAX_CLASSES];
    logic [EXP_W-1:0]     rd_data_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     rd_ptr_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic                 drop_reg;
    logic [DIVIDEND_W-1:0] dividend_reg;
    logic [SUM_W:0]       rem_reg;
    logic [QUOT_W-1:0]    quot_reg;
    logic [STEP_W-1:0]    step_reg;
    logic                 div_busy_reg;
    logic [PROB_W-1:0]    prob_reg;
    logic                 last_out_reg;
    logic                 ovf_reg;
    logic                 valid_reg;

    // Exponent from the registered product.
    logic [35:0]          biased;
    logic signed [5:0]    shift_n;
    logic [IDX_W-1:0]     frac_idx;
    logic [16:0]          word;
    logic [EXP_W-1:0]     exp_val;
    logic [SUM_W:0]       rem_shift;
    logic [SUM_W:0]       rem_sub;
    logic [QUOT_W-1:0]    quot_next;

    always_comb
    begin
        biased   = prod_reg + (36'd16 << 28);
        shift_n  = 6'(biased[35:28]) - 6'sd16;
        frac_idx = biased[27:28-IDX_W];
        word     = rom_lookup(frac_idx);
        if (shift_n >= 0)
        begin
            exp_val = EXP_W'({11'd0, word} << shift_n[3:0]);
        end
        else
        begin
            exp_val = EXP_W'(word >> 4'(-shift_n));
        end
    end

    // Capture the scaled logit.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            prod_reg <= 36'(signed'(logit) * 36'sd94548);
            last_reg <= last_in;
        end
    end

    // Store write and registered read.
    always_ff @(posedge clk)
    begin
        if (cmd.store && count_reg < CNT_W'(MAX_CLASSES))
        begin
            exp_mem[count_reg[ADDR_W-1:0]] <= exp_val;
        end
        if (cmd.read)
        begin
            rd_data_reg <= exp_mem[rd_ptr_reg[ADDR_W-1:0]];
        end
    end

    // Count, sum, drop flag and read pointer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            sum_reg    <= '0;
            drop_reg   <= 1'b0;
            rd_ptr_reg <= '0;
        end
        else if (cmd.clear)
        begin
            count_reg  <= '0;
            sum_reg    <= '0;
            drop_reg   <= 1'b0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (cmd.store)
            begin
                if (count_reg < CNT_W'(MAX_CLASSES))
                begin
                    count_reg <= count_reg + 1'b1;
                    sum_reg   <= sum_reg + SUM_W'(exp_val);
                end
                else
                begin
                    drop_reg <= 1'b1;
                end
            end
            if (cmd.emit)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Restoring divider, one quotient bit per cycle.
    always_comb
    begin
        rem_shift = {rem_reg[SUM_W-1:0], dividend_reg[DIVIDEND_W-1]};
        rem_sub   = rem_shift - {1'b0, sum_reg};
        quot_next = {quot_reg[QUOT_W-2:0], ~rem_sub[SUM_W]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            step_reg     <= '0;
        end
        else if (cmd.div_start)
        begin
            div_busy_reg <= 1'b1;
            step_reg     <= '0;
        end
        else if (div_busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == STEP_W'(DIV_STEPS - 1))
            begin
                div_busy_reg <= 1'b0;
            end
        end
    end

    // The dividend exp * 2^16 is split: its upper bits (exp >> 1) preload the
    // remainder and its low 17 bits are shifted in. Since exp <= sum the
    // quotient fits 17 bits, so the preloaded remainder is below the sum.
    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            dividend_reg <= {rd_data_reg, 16'd0} << (DIVIDEND_W - QUOT_W);
            rem_reg      <= (SUM_W + 1)'(rd_data_reg[EXP_W-1:1]);
            quot_reg     <= '0;
        end
        else if (div_busy_reg)
        begin
            dividend_reg <= dividend_reg << 1;
            quot_reg     <= quot_next;
            if (!rem_sub[SUM_W])
            begin
                rem_reg <= rem_sub;
            end
            else
            begin
                rem_reg <= rem_shift;
            end
        end
    end

    // Result register, shown for one cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= cmd.emit;
        end
    end

    // The emit cycle is the last divider step, so the final quotient bit is
    // taken straight from the subtractor.
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            prob_reg     <= quot_next[QUOT_W-1] ? PROB_W'(65535) : quot_next[PROB_W-1:0];
            last_out_reg <= (rd_ptr_reg + 1'b1) == count_reg;
            ovf_reg      <= drop_reg;
        end
    end

    assign probability = prob_reg;
    assign last_out    = last_out_reg & valid_reg;
    assign overflowed  = ovf_reg & valid_reg;

    assign status.div_done  = div_busy_reg && step_reg == STEP_W'(DIV_STEPS - 1);
    assign status.last_seen = last_reg;
    assign status.last_elem = (rd_ptr_reg + 1'b1) == count_reg;

endmodule

### design/smx_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_ctrl: sequencer of the softmax vector unit.
// Walks collect, exponent, and per element read, divide and emit phases.
// ----------------------------------------------------------------------------
module smx_ctrl
    import smx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  smx_status_t status,
    output smx_cmd_t    cmd,
    output logic        busy,
    output logic        strobe
);

    smx_state_t state_reg;
    smx_state_t state_next;
    logic       strobe_reg;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_COLLECT;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= cmd.emit;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_COLLECT:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXP;
                end
            end
            ST_EXP:
            begin
                cmd.store  = 1'b1;
                state_next = status.last_seen ? ST_READ : ST_COLLECT;
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (!status.div_done)
                begin
                    cmd.div_start = 1'b1;
                end
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.div_done)
                begin
                    cmd.emit = 1'b1;
                    if (status.last_elem)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_COLLECT;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    assign busy   = state_reg != ST_COLLECT;
    assign strobe = strobe_reg;

endmodule

### design/softmax_vector_unit_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// softmax_vector_unit_top: fixed-point softmax over a vector of logits.
// Collects Q4.12 logits, then emits one Q0.16 probability per element.
// ----------------------------------------------------------------------------
// Usage: a logit transfer happens at a clock edge with start high and busy
// low. Each logit is captured into the product register, then turned into
// an exponential and written to the store in the exponent state, while busy
// is high. After the item marked last_in, the block emits one probability
// per stored element, each shown for exactly one cycle with strobe high,
// last_out on the final one and overflowed on all of them when logits
// beyond MAX_CLASSES were dropped. Each result goes through a store read, a
// divider load, then 17 steps of the one-bit-per-cycle restoring divider,
// which sets the rate. Busy stays high through the whole emit phase. The
// receiver cannot stall; results must be taken as shown.
// Reset clears the element count, running sum and drop flag; no clearing
// pass is needed as only entries written in the current vector are read.
// ----------------------------------------------------------------------------
module softmax_vector_unit_top
    import smx_pkg::*;
#(
    parameter int MAX_CLASSES     = DEF_MAX_CLASSES,
    parameter int EXP_TABLE_DEPTH = DEF_EXP_TABLE_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] logit,
    input  logic               last_in,
    output logic               strobe,
    output logic [PROB_W-1:0]  probability,
    output logic               last_out,
    output logic               overflowed
);

    smx_cmd_t    cmd;
    smx_status_t status;

    smx_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .strobe (strobe)
    );

    smx_datapath #(
        .MAX_CLASSES     (MAX_CLASSES),
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .logit       (logit),
        .last_in     (last_in),
        .cmd         (cmd),
        .status      (status),
        .probability (probability),
        .last_out    (last_out),
        .overflowed  (overflowed)
    );

endmodule
